// File: rtl/vad_pkg.sv
// Shared types and constants of the voice activity end detector.
package vad_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int THR_W     = 24;
    localparam int ALPHA_W   = 9;
    localparam int BKT_W     = 6;
    localparam int TICK_W    = 16;
    localparam int LEVEL_W   = 24;
    localparam int END_W     = 2;
    localparam int VAR_W     = 46;
    localparam int ROOT_W    = 23;
    localparam int SQ_REM_W  = 26;
    localparam int FRAC_BITS = 16;
    localparam int EMA_SHIFT = 8;
    localparam int EMA_W     = LEVEL_W + ALPHA_W + 1;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);
    localparam logic [EMA_W-1:0]   RND_HALF  = EMA_W'(128);

    localparam logic [THR_W-1:0]   RST_THRESHOLD = THR_W'(76800);
    localparam logic [ALPHA_W-1:0] RST_ALPHA     = ALPHA_W'(77);
    localparam logic [BKT_W-1:0]   RST_CAP       = BKT_W'(20);
    localparam logic [BKT_W-1:0]   RST_FILL      = BKT_W'(5);
    localparam logic [BKT_W-1:0]   RST_LEAK      = BKT_W'(1);
    localparam logic [TICK_W-1:0]  RST_MAX_TICKS = TICK_W'(10000);

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_LAST    = 2'd1,
        OP_TICK    = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef enum logic [END_W-1:0] {
        END_NONE   = 2'd0,
        END_SPEECH = 2'd1,
        END_CAP    = 2'd2
    } end_t;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_ALPHA     = 3'd1,
        REG_CAP       = 3'd2,
        REG_FILL      = 3'd3,
        REG_LEAK      = 3'd4,
        REG_MAX_TICKS = 3'd5
    } reg_idx_t;

endpackage

// File: rtl/vad_stream_if.sv
// Input and result channel interfaces of the voice activity end detector.
interface vad_in_if;
    import vad_pkg::*;

    logic                       valid;
    logic                       ready;
    opcode_t                    opcode;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, opcode, sample, input ready);
    modport sink   (input valid, opcode, sample, output ready);
endinterface

interface vad_out_if;
    import vad_pkg::*;

    logic               valid;
    logic               ready;
    end_t               end_reason;
    logic               voice_now;
    logic               speech_heard;
    logic [BKT_W-1:0]   bucket_out;
    logic [LEVEL_W-1:0] level_out;

    modport source (output valid, end_reason, voice_now, speech_heard, bucket_out, level_out,
                    input ready);
    modport sink   (input valid, end_reason, voice_now, speech_heard, bucket_out, level_out,
                    output ready);
endinterface

// File: rtl/voice_activity_end_detector_top.sv
// Top level of the voice activity end detector: frame statistics, standard deviation, EMA, leaky bucket.
//
//  channel  | dir | beat content
//  ---------+-----+-------------------------------------------------------------
//  in_ch    | in  | opcode, sample
//  out_ch   | out | end_reason, voice_now, speech_heard, bucket_out, level_out
//  apb      | in  | register writes and reads, always ready
//
//  Ticks and restarts are handled on acceptance; a sample is accepted, then accumulated.
//  A frame-end sample then passes multiply, difference, the bit-serial divider
//  (DVD_W steps), the square root (ROOT_W steps), the EMA steps and the decision,
//  divider and root both running on the one compare-and-subtract unit.
//  rst_n clears all control and detector state; registers return to defaults.
//  A result waits in the output register; the block stalls only if a second
//  result is due while the first is still held.
module voice_activity_end_detector_top #(
    parameter int FRAME_MAX = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    vad_in_if.sink                        in_ch,
    vad_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vad_pkg::ADDR_W-1:0]    paddr,
    input  logic [vad_pkg::DATA_W-1:0]    pwdata,
    output logic [vad_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import vad_pkg::*;

    localparam int CNT_W  = $clog2(FRAME_MAX + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int MAG_W  = SUM_W - 1;
    localparam int SQ_W   = 2 * SAMPLE_W - 2 + CNT_W;
    localparam int PROD_W = 2 * MAG_W;
    localparam int N2_W   = 2 * CNT_W;
    localparam int DVD_W  = PROD_W + FRAC_BITS;
    localparam int UW     = (N2_W + 1 > SQ_REM_W) ? N2_W + 1 : SQ_REM_W;
    localparam int ITER_W = $clog2(DVD_W + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ACC    = 9'b000000010,
        S_MUL    = 9'b000000100,
        S_DIFF   = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_SQRT   = 9'b000100000,
        S_EMA1   = 9'b001000000,
        S_EMA2   = 9'b010000000,
        S_DECIDE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [THR_W-1:0]   thr_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [BKT_W-1:0]   cap_reg;
    logic [BKT_W-1:0]   fill_reg;
    logic [BKT_W-1:0]   leak_reg;
    logic [TICK_W-1:0]  max_ticks_reg;

    opcode_t                    op_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sumsq_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic [MAG_W-1:0]  mag_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [N2_W-1:0]   n2_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [UW-1:0]     rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [EMA_W-1:0]  ema_reg;

    logic [LEVEL_W-1:0] smooth_reg;
    logic [BKT_W-1:0]   bucket_reg;
    logic               voice_reg;
    logic               speech_reg;
    logic [TICK_W-1:0]  ticks_reg;

    logic               out_valid_reg;
    end_t               end_reg;
    logic               out_voice_reg;
    logic               out_speech_reg;
    logic [BKT_W-1:0]   out_bucket_reg;
    logic [LEVEL_W-1:0] out_level_reg;

    logic                         in_acc;
    logic                         cfg_wr;
    logic [2:0]                   cfg_idx;
    logic signed [2*SAMPLE_W-1:0] sq_val;
    logic signed [SUM_W-1:0]      sum_neg;
    logic [SUM_W-1:0]             sum_abs;
    logic [PROD_W-1:0]            n_sumsq;
    logic [N2_W-1:0]              n_sq;
    logic [PROD_W-1:0]            mag_sq;
    logic [PROD_W-1:0]            d_val;
    logic                         cnt_room;
    logic                         div_last;
    logic                         sqrt_last;
    logic                         out_free;

    logic [UW-1:0] unit_a;
    logic [UW-1:0] unit_b;
    logic          unit_ge;
    logic [UW-1:0] unit_diff;

    logic [ALPHA_W-1:0] alpha_eff;
    logic [LEVEL_W-1:0] lvl_sel;
    logic [EMA_W-1:0]   ema_first;
    logic [EMA_W-1:0]   ema_sum;

    logic               loud;
    logic [BKT_W:0]     fill_sum;
    logic [BKT_W-1:0]   bucket_next;
    logic               voice_next;
    logic               speech_next;
    end_t               end_next;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= RST_THRESHOLD;
            alpha_reg     <= RST_ALPHA;
            cap_reg       <= RST_CAP;
            fill_reg      <= RST_FILL;
            leak_reg      <= RST_LEAK;
            max_ticks_reg <= RST_MAX_TICKS;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_THRESHOLD: thr_reg       <= pwdata[THR_W-1:0];
                REG_ALPHA:     alpha_reg     <= pwdata[ALPHA_W-1:0];
                REG_CAP:       cap_reg       <= pwdata[BKT_W-1:0];
                REG_FILL:      fill_reg      <= pwdata[BKT_W-1:0];
                REG_LEAK:      leak_reg      <= pwdata[BKT_W-1:0];
                REG_MAX_TICKS: max_ticks_reg <= pwdata[TICK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_THRESHOLD: prdata = DATA_W'(thr_reg);
            REG_ALPHA:     prdata = DATA_W'(alpha_reg);
            REG_CAP:       prdata = DATA_W'(cap_reg);
            REG_FILL:      prdata = DATA_W'(fill_reg);
            REG_LEAK:      prdata = DATA_W'(leak_reg);
            REG_MAX_TICKS: prdata = DATA_W'(max_ticks_reg);
            default:       prdata = '0;
        endcase
    end

    // handshake
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.end_reason   = end_reg;
    assign out_ch.voice_now    = out_voice_reg;
    assign out_ch.speech_heard = out_speech_reg;
    assign out_ch.bucket_out   = out_bucket_reg;
    assign out_ch.level_out    = out_level_reg;

    // frame statistics datapath
    assign sq_val   = sample_reg * sample_reg;
    assign sum_neg  = -sum_reg;
    assign sum_abs  = sum_reg[SUM_W-1] ? unsigned'(sum_neg) : unsigned'(sum_reg);
    assign n_sumsq  = cnt_reg * sumsq_reg;
    assign n_sq     = cnt_reg * cnt_reg;
    assign mag_sq   = mag_reg * mag_reg;
    assign d_val    = prod_reg - mag_sq;
    assign cnt_room = (cnt_reg < CNT_W'(FRAME_MAX));
    assign div_last  = (iter_reg == ITER_W'(DVD_W - 1));
    assign sqrt_last = (iter_reg == ITER_W'(ROOT_W - 1));

    // shared unit: restoring division step or square-root step
    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            unit_a = UW'({rem_reg[N2_W-1:0], dvd_reg[DVD_W-1]});
            unit_b = UW'(n2_reg);
        end
        else
        begin
            unit_a = UW'({rem_reg[SQ_REM_W-3:0], dvd_reg[VAR_W-1 -: 2]});
            unit_b = UW'({root_reg, 2'b01});
        end
    end

    vad_cmpsub #(
        .WIDTH (UW)
    ) u_cmpsub (
        .a    (unit_a),
        .b    (unit_b),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    // smoothing
    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign lvl_sel   = (smooth_reg == '0) ? LEVEL_W'(root_reg) : smooth_reg;
    assign ema_first = EMA_W'(lvl_sel) * EMA_W'(ALPHA_ONE - alpha_eff);
    assign ema_sum   = ema_reg + EMA_W'(root_reg) * EMA_W'(alpha_eff) + RND_HALF;

    // bucket and decision
    assign loud     = (smooth_reg > thr_reg);
    assign fill_sum = {1'b0, bucket_reg} + {1'b0, fill_reg};

    always_comb
    begin
        if (loud)
        begin
            bucket_next = (fill_sum > {1'b0, cap_reg}) ? cap_reg : fill_sum[BKT_W-1:0];
            voice_next  = 1'b1;
        end
        else
        begin
            bucket_next = (bucket_reg > leak_reg) ? bucket_reg - leak_reg : '0;
            voice_next  = (bucket_next == '0) ? 1'b0 : voice_reg;
        end
        speech_next = speech_reg || loud;
        if (speech_next && bucket_next == '0)
            end_next = END_SPEECH;
        else if (ticks_reg >= max_ticks_reg)
            end_next = END_CAP;
        else
            end_next = END_NONE;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (in_ch.opcode inside {OP_SAMPLE, OP_LAST}))
                    state_next = S_ACC;
            end
            S_ACC:    state_next = (op_reg == OP_LAST) ? S_MUL : S_IDLE;
            S_MUL:    state_next = S_DIFF;
            S_DIFF:   state_next = S_DIV;
            S_DIV:    state_next = div_last ? S_SQRT : S_DIV;
            S_SQRT:   state_next = sqrt_last ? S_EMA1 : S_SQRT;
            S_EMA1:   state_next = S_EMA2;
            S_EMA2:   state_next = S_DECIDE;
            S_DECIDE: state_next = out_free ? S_IDLE : S_DECIDE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            cnt_reg       <= '0;
            iter_reg      <= '0;
            smooth_reg    <= '0;
            bucket_reg    <= '0;
            voice_reg     <= 1'b0;
            speech_reg    <= 1'b0;
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DECIDE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && in_ch.opcode == OP_TICK && ticks_reg != '1)
                        ticks_reg <= ticks_reg + 1'b1;
                    if (in_acc && in_ch.opcode == OP_RESTART)
                    begin
                        bucket_reg <= '0;
                        voice_reg  <= 1'b0;
                        speech_reg <= 1'b0;
                        smooth_reg <= '0;
                        ticks_reg  <= '0;
                    end
                end
                S_ACC:
                begin
                    if (cnt_room)
                    begin
                        sum_reg   <= sum_reg + SUM_W'(sample_reg);
                        sumsq_reg <= sumsq_reg + SQ_W'(sq_val[2*SAMPLE_W-2:0]);
                        cnt_reg   <= cnt_reg + 1'b1;
                    end
                end
                S_MUL:
                begin
                    sum_reg   <= '0;
                    sumsq_reg <= '0;
                    cnt_reg   <= '0;
                end
                S_DIFF:   iter_reg <= '0;
                S_DIV:    iter_reg <= div_last ? '0 : iter_reg + 1'b1;
                S_SQRT:   iter_reg <= iter_reg + 1'b1;
                S_EMA2:   smooth_reg <= LEVEL_W'(ema_sum >> EMA_SHIFT);
                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        bucket_reg <= bucket_next;
                        voice_reg  <= voice_next;
                        speech_reg <= speech_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_reg     <= in_ch.opcode;
                    sample_reg <= in_ch.sample;
                end
            end
            S_MUL:
            begin
                prod_reg <= n_sumsq;
                n2_reg   <= n_sq;
                mag_reg  <= sum_abs[MAG_W-1:0];
            end
            S_DIFF:
            begin
                dvd_reg <= {d_val, FRAC_BITS'(0)};
                rem_reg <= '0;
            end
            S_DIV:
            begin
                dvd_reg <= {dvd_reg[DVD_W-2:0], unit_ge};
                if (div_last)
                begin
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                else
                    rem_reg <= unit_ge ? unit_diff : unit_a;
            end
            S_SQRT:
            begin
                rem_reg  <= unit_ge ? unit_diff : unit_a;
                root_reg <= {root_reg[ROOT_W-2:0], unit_ge};
                dvd_reg  <= {dvd_reg[DVD_W-3:0], 2'b00};
            end
            S_EMA1: ema_reg <= ema_first;
            S_DECIDE:
            begin
                if (out_free)
                begin
                    end_reg        <= end_next;
                    out_voice_reg  <= voice_next;
                    out_speech_reg <= speech_next;
                    out_bucket_reg <= bucket_next;
                    out_level_reg  <= smooth_reg;
                end
            end
            default: ;
        endcase
    end
endmodule

// File: rtl/vad_cmpsub.sv
// Shared compare-and-subtract step used by the divider and the square root.
module vad_cmpsub #(
    parameter int WIDTH = 26
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             ge,
    output logic [WIDTH-1:0] diff
);
    logic [WIDTH:0] full;

    assign full = {1'b0, a} - {1'b0, b};
    assign ge   = ~full[WIDTH];
    assign diff = full[WIDTH-1:0];
endmodule

// File: rtl/vad_checker.sv
// Port-level assertions for the voice activity end detector, bound to the top level.
module vad_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [1:0]                    in_opcode,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [vad_pkg::END_W-1:0]     end_reason,
    input logic                          voice_now,
    input logic                          speech_heard,
    input logic [vad_pkg::BKT_W-1:0]     bucket_out,
    input logic [vad_pkg::LEVEL_W-1:0]   level_out
);
    import vad_pkg::*;

    // a sample beat keeps the block busy in the cycle after it is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_opcode == OP_SAMPLE || in_opcode == OP_LAST)
        |=> !in_ready)
        else $error("input accepted during sample accumulation");

    // speech end only with an empty bucket after speech
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_reason == END_SPEECH |-> speech_heard && bucket_out == '0)
        else $error("speech end reported with bucket or flag inconsistent");

    // no speech yet means no voice and an empty bucket
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !speech_heard |-> !voice_now && bucket_out == '0)
        else $error("voice or bucket set without speech");

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level_out) && $stable(end_reason)
        && $stable(bucket_out))
        else $error("result beat changed while stalled");
endmodule

bind voice_activity_end_detector_top vad_checker u_vad_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_opcode    (in_ch.opcode),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .end_reason   (out_ch.end_reason),
    .voice_now    (out_ch.voice_now),
    .speech_heard (out_ch.speech_heard),
    .bucket_out   (out_ch.bucket_out),
    .level_out    (out_ch.level_out)
);
